// File: sv/dhp_pkg.sv
package dhp_pkg;

  // ASCII codes used by the header grammar
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;

  // header byte counter width; covers every header length limit up to 127
  localparam int unsigned HDR_LEN_W = 7;
  localparam int unsigned LINE_W    = 32;

  typedef enum logic [1:0] {
    MK_APPEND = 2'd0,
    MK_CHANGE = 2'd1,
    MK_DELETE = 2'd2
  } mark_kind_e;

  typedef enum logic [1:0] {
    PH_OLD_START = 2'd0,
    PH_OLD_END   = 2'd1,
    PH_NEW_START = 2'd2,
    PH_NEW_END   = 2'd3
  } phase_e;

  typedef struct packed {
    mark_kind_e         kind;
    logic [LINE_W-1:0]  first_line;
    logic [LINE_W-1:0]  last_line;
  } mark_t;

  function automatic logic is_kind_letter(input logic [7:0] b);
    return (b == CH_A) || (b == CH_C) || (b == CH_D);
  endfunction

  function automatic mark_kind_e kind_of_letter(input logic [7:0] b);
    mark_kind_e k;
    case (b)
      CH_A:    k = MK_APPEND;
      CH_C:    k = MK_CHANGE;
      default: k = MK_DELETE;
    endcase
    return k;
  endfunction

endpackage

// File: sv/diff_hunk_header_parser_core.sv
// Normal-format diff hunk header parser.
// Input channel (in_valid_i / in_stall_o): one byte of diff text per
// transaction, with stream_end_i marking end of input (the byte is then
// ignored, a pending header is flushed and the parser returns to line start).
// Output channel (out_valid_o / out_stall_i): one mark per well-formed
// header, issued on the CR/LF or stream end that closes it.
// Configuration: cfg_we_i writes cfg_wdata_i into edited_is_old, which picks
// the old- or new-file side of the header; write only while idle.
// Throughput: one byte per cycle while in_stall_o is low; the parser state
// updates in the accepting cycle and the mark is registered in the output
// register, or in the skid entry while the output register is held.
// The output side is a two-entry register pair; in_stall_o rises only once
// both entries hold marks, i.e. after the receiver has stalled and a further
// mark arrived. Bytes that close no header keep flowing meanwhile.
// Reset: parser at line start, no header open, edited_is_old = 0, output
// empty. Stream end keeps the configuration.
module diff_hunk_header_parser_core #(
  parameter int unsigned MAX_HEADER_LEN = 99,
  parameter int unsigned LINE_BITS      = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  input  logic                stream_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          mark_kind_o,
  output logic signed [31:0]  first_line_o,
  output logic signed [31:0]  last_line_o
);
  import dhp_pkg::*;

  logic  edited_is_old_q;
  logic  take, res_valid, full;
  mark_t res, out_mark;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edited_is_old_q <= 1'b0;
    end else if (cfg_we_i) begin
      edited_is_old_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  dhp_parse #(
    .MAX_HEADER_LEN (MAX_HEADER_LEN),
    .LINE_BITS      (LINE_BITS)
  ) u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .in_byte_i       (in_byte_i),
    .stream_end_i    (stream_end_i),
    .edited_is_old_i (edited_is_old_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  dhp_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_mark),
    .full_o      (full)
  );

  assign mark_kind_o  = out_mark.kind;
  assign first_line_o = out_mark.first_line;
  assign last_line_o  = out_mark.last_line;

endmodule

// File: sv/dhp_parse.sv
module dhp_parse #(
  parameter int unsigned MAX_HEADER_LEN = 99,
  parameter int unsigned LINE_BITS      = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     in_byte_i,
  input  logic           stream_end_i,
  input  logic           edited_is_old_i,
  output logic           res_valid_o,
  output dhp_pkg::mark_t res_o
);
  import dhp_pkg::*;

  localparam int unsigned EXT_W  = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
  localparam int unsigned PROD_W = LINE_BITS + 4;

  logic                 at_head_q, at_head_d;
  logic                 collecting_q, collecting_d;
  logic [HDR_LEN_W-1:0] hdr_len_q, hdr_len_d;
  phase_e               phase_q, phase_d;
  logic                 bad_q, bad_d;
  logic [LINE_BITS-1:0] old_start_q, old_start_d, old_end_q, old_end_d;
  logic [LINE_BITS-1:0] new_start_q, new_start_d, new_end_q, new_end_d;
  logic                 old_comma_q, old_comma_d, new_comma_q, new_comma_d;
  mark_kind_e           mode_q, mode_d;

  logic                 eol, is_digit, finish;
  logic [3:0]           digit;
  logic [LINE_BITS-1:0] sel_num, acc_num;
  logic [PROD_W-1:0]    prod;
  logic [HDR_LEN_W-1:0] len_inc;

  logic [LINE_BITS-1:0] s_num, e_num;
  logic [EXT_W-1:0]     s_ext, e_ext, first_ext, last_ext;
  logic                 shift;
  mark_kind_e           kind;

  assign eol      = (in_byte_i == CH_LF) || (in_byte_i == CH_CR);
  assign is_digit = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE);
  assign digit    = 4'(in_byte_i - CH_ZERO);
  assign len_inc  = hdr_len_q + HDR_LEN_W'(1);

  // one decimal accumulate for whichever number is open, saturating
  always_comb begin
    case (phase_q)
      PH_OLD_START: sel_num = old_start_q;
      PH_OLD_END:   sel_num = old_end_q;
      PH_NEW_START: sel_num = new_start_q;
      default:      sel_num = new_end_q;
    endcase
    prod = {sel_num, 3'b000} + {2'b00, sel_num, 1'b0} + PROD_W'(digit);
    if (prod > PROD_W'({LINE_BITS{1'b1}})) begin
      acc_num = '1;
    end else begin
      acc_num = prod[LINE_BITS-1:0];
    end
  end

  // range mapping for the collected header
  always_comb begin
    if (edited_is_old_i) begin
      s_num = old_start_q;
      e_num = old_comma_q ? old_end_q : old_start_q;
      case (mode_q)
        MK_APPEND: kind = MK_DELETE;
        MK_CHANGE: kind = MK_CHANGE;
        default:   kind = MK_APPEND;
      endcase
      shift = (mode_q != MK_APPEND);
    end else begin
      s_num = new_start_q;
      e_num = new_comma_q ? new_end_q : new_start_q;
      kind  = mode_q;
      shift = (mode_q != MK_DELETE);
    end
    s_ext     = EXT_W'(s_num);
    e_ext     = EXT_W'(e_num);
    first_ext = shift ? s_ext - EXT_W'(1) : s_ext;
    last_ext  = shift ? e_ext - EXT_W'(1) : e_ext;
  end

  assign finish = (stream_end_i || (!at_head_q && eol)) && collecting_q &&
                  (hdr_len_q != '0) && !bad_q &&
                  (phase_q == PH_NEW_START || phase_q == PH_NEW_END);

  assign res_valid_o      = take_i && finish;
  assign res_o.kind       = kind;
  assign res_o.first_line = first_ext[LINE_W-1:0];
  assign res_o.last_line  = last_ext[LINE_W-1:0];

  always_comb begin
    at_head_d    = at_head_q;
    collecting_d = collecting_q;
    hdr_len_d    = hdr_len_q;
    phase_d      = phase_q;
    bad_d        = bad_q;
    old_start_d  = old_start_q;
    old_end_d    = old_end_q;
    new_start_d  = new_start_q;
    new_end_d    = new_end_q;
    old_comma_d  = old_comma_q;
    new_comma_d  = new_comma_q;
    mode_d       = mode_q;

    if (stream_end_i) begin
      at_head_d    = 1'b1;
      collecting_d = 1'b0;
      hdr_len_d    = '0;
      phase_d      = PH_OLD_START;
      bad_d        = 1'b0;
      old_start_d  = '0;
      old_end_d    = '0;
      new_start_d  = '0;
      new_end_d    = '0;
      old_comma_d  = 1'b0;
      new_comma_d  = 1'b0;
      mode_d       = MK_APPEND;
    end else if (at_head_q) begin
      if (!eol) begin
        at_head_d = 1'b0;
        if (is_digit) begin
          collecting_d = 1'b1;
          hdr_len_d    = HDR_LEN_W'(1);
          phase_d      = PH_OLD_START;
          bad_d        = 1'b0;
          old_start_d  = LINE_BITS'(digit);
          old_end_d    = '0;
          new_start_d  = '0;
          new_end_d    = '0;
          old_comma_d  = 1'b0;
          new_comma_d  = 1'b0;
          mode_d       = MK_APPEND;
        end
      end
    end else if (eol) begin
      hdr_len_d    = '0;
      collecting_d = 1'b0;
      at_head_d    = 1'b1;
    end else if (collecting_q) begin
      if (!bad_q) begin
        if (is_digit) begin
          case (phase_q)
            PH_OLD_START: old_start_d = acc_num;
            PH_OLD_END:   old_end_d   = acc_num;
            PH_NEW_START: new_start_d = acc_num;
            default:      new_end_d   = acc_num;
          endcase
        end else if (phase_q == PH_OLD_START && in_byte_i == CH_COMMA) begin
          old_comma_d = 1'b1;
          phase_d     = PH_OLD_END;
        end else if ((phase_q == PH_OLD_START || phase_q == PH_OLD_END) &&
                     is_kind_letter(in_byte_i)) begin
          mode_d  = kind_of_letter(in_byte_i);
          phase_d = PH_NEW_START;
        end else if (phase_q == PH_NEW_START && in_byte_i == CH_COMMA) begin
          new_comma_d = 1'b1;
          phase_d     = PH_NEW_END;
        end else begin
          bad_d = 1'b1;
        end
      end
      // overlong header: drop it, rest of the line is ignored
      if (len_inc >= HDR_LEN_W'(MAX_HEADER_LEN)) begin
        hdr_len_d    = '0;
        collecting_d = 1'b0;
      end else begin
        hdr_len_d = len_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_head_q    <= 1'b1;
      collecting_q <= 1'b0;
      hdr_len_q    <= '0;
      phase_q      <= PH_OLD_START;
      bad_q        <= 1'b0;
      old_comma_q  <= 1'b0;
      new_comma_q  <= 1'b0;
      mode_q       <= MK_APPEND;
    end else if (take_i) begin
      at_head_q    <= at_head_d;
      collecting_q <= collecting_d;
      hdr_len_q    <= hdr_len_d;
      phase_q      <= phase_d;
      bad_q        <= bad_d;
      old_comma_q  <= old_comma_d;
      new_comma_q  <= new_comma_d;
      mode_q       <= mode_d;
    end
  end

  // numbers are always reloaded at header start before they are read
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      old_start_q <= old_start_d;
      old_end_q   <= old_end_d;
      new_start_q <= new_start_d;
      new_end_q   <= new_end_d;
    end
  end

endmodule

// File: sv/dhp_obuf.sv
module dhp_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dhp_pkg::mark_t push_data_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output dhp_pkg::mark_t out_data_o,
  output logic           full_o
);
  import dhp_pkg::*;

  logic  out_valid_q, out_valid_d;
  logic  skid_valid_q, skid_valid_d;
  mark_t out_q, out_d;
  mark_t skid_q, skid_d;
  logic  pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // input is stalled while the skid entry is occupied
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full_o      = skid_valid_q;

endmodule

// File: bench/diff_hunk_header_parser_core_tb.sv
module diff_hunk_header_parser_core_tb;
  import dhp_pkg::*;

  localparam int unsigned HDR_LIMIT    = 99;
  localparam int unsigned NUM_BITS     = 31;
  localparam longint unsigned NUM_SAT  = (64'd1 << NUM_BITS) - 64'd1;
  localparam int unsigned ITEM_TARGET  = 1000;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         in_byte_i;
  logic               stream_end_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         mark_kind_o;
  logic signed [31:0] first_line_o;
  logic signed [31:0] last_line_o;

  diff_hunk_header_parser_core #(
    .MAX_HEADER_LEN(HDR_LIMIT),
    .LINE_BITS     (NUM_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .stream_end_i(stream_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mark_kind_o (mark_kind_o),
    .first_line_o(first_line_o),
    .last_line_o (last_line_o)
  );

  // header parser mirror
  logic                 side_old;
  logic                 line_head;
  logic                 in_header;
  logic [HDR_LEN_W-1:0] hdr_len;
  phase_e               field;
  logic                 hdr_broken;
  logic [NUM_BITS-1:0]  old_first, old_last, new_first, new_last;
  logic                 old_comma, new_comma;
  mark_kind_e           letter;
  mark_t                marks_due[$];

  logic [7:0]  line_buf[$];
  bit          steady_flow;
  bit          hold_request;
  int unsigned items_sent;
  int unsigned err_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void parser_clear();
    line_head  = 1'b1;
    in_header  = 1'b0;
    hdr_len    = '0;
    field      = PH_OLD_START;
    hdr_broken = 1'b0;
    old_first  = '0;
    old_last   = '0;
    new_first  = '0;
    new_last   = '0;
    old_comma  = 1'b0;
    new_comma  = 1'b0;
    letter     = MK_APPEND;
  endfunction

  function automatic logic [NUM_BITS-1:0] push_digit(input logic [NUM_BITS-1:0] v,
                                                     input logic [7:0] ch);
    longint unsigned acc;
    longint unsigned d;
    acc = v;
    d   = ch - CH_ZERO;
    acc = acc * 10 + d;
    return (acc > NUM_SAT) ? NUM_SAT[NUM_BITS-1:0] : acc[NUM_BITS-1:0];
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return (b == CH_A) || (b == CH_C) || (b == CH_D);
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    if (hdr_broken) begin
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      case (field)
        PH_OLD_START: old_first = push_digit(old_first, b);
        PH_OLD_END:   old_last  = push_digit(old_last, b);
        PH_NEW_START: new_first = push_digit(new_first, b);
        default:      new_last  = push_digit(new_last, b);
      endcase
    end else if (field == PH_OLD_START && b == CH_COMMA) begin
      old_comma = 1'b1;
      field     = PH_OLD_END;
    end else if ((field == PH_OLD_START || field == PH_OLD_END) && is_letter(b)) begin
      letter = (b == CH_A) ? MK_APPEND : (b == CH_C) ? MK_CHANGE : MK_DELETE;
      field  = PH_NEW_START;
    end else if (field == PH_NEW_START && b == CH_COMMA) begin
      new_comma = 1'b1;
      field     = PH_NEW_END;
    end else begin
      hdr_broken = 1'b1;
    end
  endfunction

  // a closed header yields a mark only once the kind letter has been seen
  function automatic void close_header();
    logic [NUM_BITS-1:0] s, e;
    logic                shift;
    mark_t               m;
    if (!hdr_broken && (field == PH_NEW_START || field == PH_NEW_END)) begin
      if (side_old) begin
        s = old_first;
        e = old_comma ? old_last : old_first;
        case (letter)
          MK_APPEND: m.kind = MK_DELETE;
          MK_CHANGE: m.kind = MK_CHANGE;
          default:   m.kind = MK_APPEND;
        endcase
        shift = (letter != MK_APPEND);
      end else begin
        s = new_first;
        e = new_comma ? new_last : new_first;
        m.kind = letter;
        shift  = (letter != MK_DELETE);
      end
      m.first_line = LINE_W'(s) - LINE_W'(shift);
      m.last_line  = LINE_W'(e) - LINE_W'(shift);
      marks_due.push_back(m);
    end
  endfunction

  function automatic void hunk_step(input logic [7:0] b, input logic se);
    logic eol;
    eol = (b == CH_LF) || (b == CH_CR);
    if (se) begin
      if (in_header && hdr_len != 0) close_header();
      parser_clear();
    end else if (line_head) begin
      if (!eol) begin
        line_head = 1'b0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
          in_header  = 1'b1;
          hdr_len    = HDR_LEN_W'(1);
          field      = PH_OLD_START;
          hdr_broken = 1'b0;
          old_first  = NUM_BITS'(b - CH_ZERO);
          old_last   = '0;
          new_first  = '0;
          new_last   = '0;
          old_comma  = 1'b0;
          new_comma  = 1'b0;
          letter     = MK_APPEND;
        end
      end
    end else if (eol) begin
      if (in_header && hdr_len != 0) close_header();
      hdr_len   = '0;
      in_header = 1'b0;
      line_head = 1'b1;
    end else if (in_header) begin
      absorb_byte(b);
      hdr_len = hdr_len + 1'b1;
      // too long: drop it and skip to the end of the line
      if (hdr_len >= HDR_LIMIT) begin
        hdr_len   = '0;
        in_header = 1'b0;
      end
    end
  endfunction

  function automatic void report_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, what, $signed(want),
             $signed(got));
    err_count++;
  endfunction

  function automatic void check_mark();
    mark_t want;
    if (marks_due.size() == 0) begin
      $display("%0t: unexpected mark, expected none got kind %0d first %0d last %0d",
               $time, mark_kind_o, first_line_o, last_line_o);
      err_count++;
    end else begin
      want = marks_due.pop_front();
      if (mark_kind_o !== want.kind)
        report_field("mark_kind", 32'(want.kind), 32'(mark_kind_o));
      if (first_line_o !== want.first_line)
        report_field("first_line", want.first_line, first_line_o);
      if (last_line_o !== want.last_line)
        report_field("last_line", want.last_line, last_line_o);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) hunk_step(in_byte_i, stream_end_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_mark();
  end

  // mark receiver: random stall per transaction, or one long hold on request
  initial begin : receiver
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_request) begin
        hold         = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = steady_flow ? 0 : $urandom_range(0, 10);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL diff_hunk_header_parser_core");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic se);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    stream_end_i <= se;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_stream_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (marks_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_side(input logic v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    side_old  = v;
  endtask

  function automatic void put_number(input longint unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) line_buf.push_back(digits[i]);
  endfunction

  // mostly small numbers, some at and past saturation, some empty
  function automatic void put_field(input bit may_be_empty);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0 && may_be_empty) begin
    end else if (pick < 12) put_number($urandom_range(0, 999));
    else if (pick < 16) put_number($urandom_range(0, 9));
    else if (pick == 16) put_number(NUM_SAT);
    else if (pick == 17) put_number(NUM_SAT + 1);
    else if (pick == 18) put_number({$urandom, $urandom});
    else put_number($urandom);
  endfunction

  function automatic void put_header();
    put_field(1'b0);
    if ($urandom_range(0, 1)) begin
      line_buf.push_back(CH_COMMA);
      put_field(1'b1);
    end
    case ($urandom_range(0, 2))
      0:       line_buf.push_back(CH_A);
      1:       line_buf.push_back(CH_C);
      default: line_buf.push_back(CH_D);
    endcase
    put_field(1'b1);
    if ($urandom_range(0, 1)) begin
      line_buf.push_back(CH_COMMA);
      put_field(1'b1);
    end
  endfunction

  task automatic random_line();
    int unsigned pick;
    int unsigned len;
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      put_header();
    end else if (pick < 75) begin
      // header with one stray byte
      put_header();
      line_buf[$urandom_range(1, line_buf.size() - 1)] =
        ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    end else if (pick < 88) begin
      len = $urandom_range(1, 12);
      repeat (len) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      // lengths around the header limit
      len = $urandom_range(HDR_LIMIT - 4, HDR_LIMIT + 3);
      line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      line_buf.push_back(CH_A);
      while (line_buf.size() < len) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) line_buf.push_back(CH_C);
    end else begin
      // no kind letter
      put_field(1'b0);
      if ($urandom_range(0, 1)) begin
        line_buf.push_back(CH_COMMA);
        put_field(1'b1);
      end
    end
    foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: send_item(CH_LF, 1'b0);
      5, 6:          send_item(CH_CR, 1'b0);
      7: begin
        send_item(CH_CR, 1'b0);
        send_item(CH_LF, 1'b0);
      end
      8:       send_stream_end();
      default: begin
        send_item(CH_LF, 1'b0);
        send_item(CH_LF, 1'b0);
      end
    endcase
  endtask

  task automatic test_directed_forms();
    send_text("0a0\n");
    send_text("5,7c8,10\r");
    send_text("1,d\n");
    send_text("2147483648a1,2a\n");
    send_text("1a2");
    send_item(8'h00, 1'b0);
    send_text("\n");
    send_text("9\r\n");
    send_text("4c5");
    send_stream_end();
  endtask

  task automatic test_random_lines(input int unsigned until_total);
    while (items_sent < until_total) random_line();
  endtask

  task automatic test_steady_flow(input int unsigned until_total);
    steady_flow = 1'b1;
    test_random_lines(until_total);
    steady_flow = 1'b0;
  endtask

  // receiver holds off while headers keep coming, so the block backs up
  task automatic test_backpressure();
    hold_request = 1'b1;
    steady_flow  = 1'b1;
    repeat (30) begin
      line_buf.delete();
      put_header();
      foreach (line_buf[i]) send_item(line_buf[i], 1'b0);
      send_item(CH_LF, 1'b0);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_valid_i   = 1'b0;
    in_byte_i    = '0;
    stream_end_i = 1'b0;
    steady_flow  = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    err_count    = 0;
    side_old     = 1'b0;
    parser_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_side(1'b0);
    test_directed_forms();
    test_random_lines(350);
    write_side(1'b1);
    test_directed_forms();
    test_random_lines(650);
    test_steady_flow(800);
    test_backpressure();
    write_side(1'b0);
    test_random_lines(ITEM_TARGET);
    write_side(1'b1);
    test_random_lines(ITEM_TARGET + 100);

    wait_drained();
    if (err_count == 0)
      $display("PASS diff_hunk_header_parser_core");
    else
      $display("FAIL diff_hunk_header_parser_core");
    $finish;
  end

endmodule

// File: files.f
sv/dhp_pkg.sv
sv/dhp_parse.sv
sv/dhp_obuf.sv
sv/diff_hunk_header_parser_core.sv
bench/diff_hunk_header_parser_core_tb.sv
